[sv/ps2hds_pkg.sv]
// ----------------------------------------------------------------------------
// ps2hds_pkg
// Shared types, register codes and frame helpers for the PS/2 host probe.
// ----------------------------------------------------------------------------
package ps2hds_pkg;

  // Frame and field widths
  localparam int FRAME_BITS  = 11;
  localparam int BIT_CNT_W   = 4;
  localparam int PH_TMR_W    = 19;
  localparam int CMD_TMR_W   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 19;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INHIBIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS  = 3'd4;

  // Reset values of the registers
  localparam logic [15:0] TIMEOUT_RST     = 16'd30000;
  localparam logic [15:0] IDLE_HIGH_RST   = 16'd10000;
  localparam logic [11:0] INHIBIT_RST     = 12'd500;
  localparam logic [18:0] ROUND_DELAY_RST = 19'd350000;
  localparam logic [2:0]  MAX_ROUNDS_RST  = 3'd5;

  // Probe commands
  localparam logic [7:0] CMD_PROBE_A = 8'h77;
  localparam logic [7:0] CMD_PROBE_B = 8'hFF;

  typedef struct packed {
    logic kind;
    logic clk_line;
  } in_item_t;

  typedef struct packed {
    logic clk_drive;
    logic clk_level;
    logic data_drive;
    logic data_level;
    logic busy_res;
    logic finished;
    logic detected;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_us;
    logic [15:0] idle_high_us;
    logic [11:0] inhibit_us;
    logic [18:0] round_delay_us;
    logic [2:0]  max_rounds;
  } cfg_t;

  // Command byte for a position in the round; the spare slot repeats 0x77
  function automatic logic [7:0] probe_byte(input logic [1:0] idx);
    logic [7:0] b;
    begin
      case (idx)
        2'd1:    b = CMD_PROBE_B;
        default: b = CMD_PROBE_A;
      endcase
      return b;
    end
  endfunction

  // Build start, data LSB first, odd parity, stop
  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [7:0] b);
    begin
      return {1'b1, ~(^b), b, 1'b0};
    end
  endfunction

endpackage

[sv/ps2hds_cfg.sv]
// ----------------------------------------------------------------------------
// ps2hds_cfg
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
module ps2hds_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [ps2hds_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ps2hds_pkg::CFG_DATA_W-1:0] wr_data,
  output ps2hds_pkg::cfg_t                  cfg
);
  import ps2hds_pkg::*;

  cfg_t cfg_r;

  // Load the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_us     <= TIMEOUT_RST;
      cfg_r.idle_high_us   <= IDLE_HIGH_RST;
      cfg_r.inhibit_us     <= INHIBIT_RST;
      cfg_r.round_delay_us <= ROUND_DELAY_RST;
      cfg_r.max_rounds     <= MAX_ROUNDS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_TIMEOUT:     cfg_r.timeout_us     <= wr_data[15:0];
        REG_IDLE_HIGH:   cfg_r.idle_high_us   <= wr_data[15:0];
        REG_INHIBIT:     cfg_r.inhibit_us     <= wr_data[11:0];
        REG_ROUND_DELAY: cfg_r.round_delay_us <= wr_data[18:0];
        REG_MAX_ROUNDS:  cfg_r.max_rounds     <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/ps2hds_core.sv]
// ----------------------------------------------------------------------------
// ps2hds_core
// Sequencer state and its single-pass update for one accepted item.
// ----------------------------------------------------------------------------
module ps2hds_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_en,
  input  ps2hds_pkg::in_item_t  item,
  input  ps2hds_pkg::cfg_t      cfg,
  output ps2hds_pkg::out_item_t res
);
  import ps2hds_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ROUND   = 3'd1,
    PH_HIGH    = 3'd2,
    PH_INHIBIT = 3'd3,
    PH_SHIFT   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [2:0]            round_count;
    logic [1:0]            command_index;
    logic [FRAME_BITS-1:0] frame_shift;
    logic [BIT_CNT_W-1:0]  bit_count;
    logic                  wait_for_high;
    logic [PH_TMR_W-1:0]   phase_timer;
    logic [CMD_TMR_W-1:0]  command_timer;
    logic                  found_flag;
  } state_t;

  state_t               st_r, st_nxt;
  logic                 ended;
  logic [PH_TMR_W-1:0]  tmr_inc;
  logic [CMD_TMR_W-1:0] cmd_inc;
  logic [1:0]           ci_inc;
  logic [2:0]           rc_inc;
  logic [BIT_CNT_W-1:0] bc_inc;

  // Load a fresh send for the given command slot
  function automatic state_t start_send(input state_t s, input logic [1:0] ci);
    state_t t;
    begin
      t               = s;
      t.command_index = ci;
      t.phase         = PH_HIGH;
      t.phase_timer   = '0;
      t.command_timer = '0;
      t.frame_shift   = build_frame(probe_byte(ci));
      t.bit_count     = '0;
      t.wait_for_high = 1'b0;
      return t;
    end
  endfunction

  // Next state for the accepted item
  always_comb begin
    st_nxt  = st_r;
    ended   = 1'b0;
    tmr_inc = st_r.phase_timer + PH_TMR_W'(1);
    cmd_inc = (st_r.command_timer == '1) ? st_r.command_timer
                                         : st_r.command_timer + CMD_TMR_W'(1);
    ci_inc  = st_r.command_index + 2'd1;
    rc_inc  = st_r.round_count + 3'd1;
    bc_inc  = st_r.bit_count + BIT_CNT_W'(1);
    if (item.kind) begin
      if (st_r.phase == PH_IDLE) begin
        st_nxt.round_count   = '0;
        st_nxt.command_index = '0;
        st_nxt.found_flag    = 1'b0;
        st_nxt.phase         = PH_ROUND;
        st_nxt.phase_timer   = '0;
      end
    end else begin
      case (st_r.phase)
        PH_IDLE: ;
        PH_ROUND: begin
          st_nxt.phase_timer = tmr_inc;
          if (tmr_inc >= cfg.round_delay_us) begin
            st_nxt = start_send(st_r, st_r.command_index);
          end
        end
        PH_HIGH: begin
          st_nxt.command_timer = cmd_inc;
          st_nxt.phase_timer   = tmr_inc;
          if (tmr_inc >= PH_TMR_W'(cfg.idle_high_us)) begin
            st_nxt.phase       = PH_INHIBIT;
            st_nxt.phase_timer = '0;
          end
        end
        PH_INHIBIT: begin
          st_nxt.command_timer = cmd_inc;
          st_nxt.phase_timer   = tmr_inc;
          if (tmr_inc >= PH_TMR_W'(cfg.inhibit_us)) begin
            st_nxt.phase       = PH_SHIFT;
            st_nxt.phase_timer = '0;
          end
        end
        PH_SHIFT: begin
          st_nxt.command_timer = cmd_inc;
          if (cmd_inc >= cfg.timeout_us) begin
            // Send timed out: next command, next round or give up
            st_nxt.command_index = ci_inc;
            if (ci_inc != 2'd3) begin
              st_nxt = start_send(st_nxt, ci_inc);
            end else begin
              st_nxt.round_count = rc_inc;
              if (rc_inc >= cfg.max_rounds) begin
                st_nxt.phase      = PH_IDLE;
                st_nxt.found_flag = 1'b0;
                ended             = 1'b1;
              end else begin
                st_nxt.command_index = '0;
                st_nxt.phase         = PH_ROUND;
                st_nxt.phase_timer   = '0;
              end
            end
          end else if (!st_r.wait_for_high) begin
            if (!item.clk_line) begin
              st_nxt.wait_for_high = 1'b1;
            end
          end else if (item.clk_line) begin
            // Low-then-high seen: advance to the next frame bit
            st_nxt.frame_shift   = st_r.frame_shift >> 1;
            st_nxt.bit_count     = bc_inc;
            st_nxt.wait_for_high = 1'b0;
            if (bc_inc >= BIT_CNT_W'(FRAME_BITS)) begin
              st_nxt.phase      = PH_IDLE;
              st_nxt.found_flag = 1'b1;
              ended             = 1'b1;
            end
          end
        end
        default: st_nxt.phase = PH_IDLE;
      endcase
    end
  end

  // Line drive and status from the updated state
  always_comb begin
    res = '0;
    case (st_nxt.phase)
      PH_HIGH: begin
        res.clk_drive  = 1'b1;
        res.clk_level  = 1'b1;
        res.data_drive = 1'b1;
        res.data_level = 1'b1;
      end
      PH_INHIBIT: begin
        res.clk_drive  = 1'b1;
        res.data_drive = 1'b1;
        res.data_level = 1'b1;
      end
      PH_SHIFT: begin
        res.data_drive = 1'b1;
        res.data_level = st_nxt.frame_shift[0];
      end
      default: ;
    endcase
    res.busy_res = (st_nxt.phase != PH_IDLE);
    res.finished = ended;
    res.detected = st_nxt.found_flag;
  end

  // Hold state; advance only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (item_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

[sv/ps2hds_out_reg.sv]
// ----------------------------------------------------------------------------
// ps2hds_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module ps2hds_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ps2hds_pkg::out_item_t load_data,
  output logic                  full,
  input  logic                  take_stall,
  output logic                  out_valid,
  output ps2hds_pkg::out_item_t out_data
);
  import ps2hds_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  // Slot frees when empty or when the held item leaves this cycle
  assign full = valid_r & take_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!take_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the new item
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[sv/ps2hds_sender.sv]
// ----------------------------------------------------------------------------
// ps2_host_detect_sender
// PS/2 host-side device probe driving clock and data line controls.
// ----------------------------------------------------------------------------
// Feed one item per microsecond: a tick carrying the sampled clock line, or a
// start command. Each accepted item yields exactly one result showing the line
// drives and status after that item. The block takes one item per clock cycle
// unless in_stall is high; the state update is a single pass from the state
// registers into the result register, so out_valid rises in the cycle after
// acceptance. in_stall is raised only while a result is held and out_stall is
// high. Register writes are applied at once and may be issued at any time.
module ps2_host_detect_sender (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ps2hds_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ps2hds_pkg::out_item_t             out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2hds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ps2hds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ps2hds_pkg::*;

  cfg_t      cfg;
  out_item_t res;
  logic      accept;
  logic      slot_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = slot_full;
  assign accept    = in_valid & ~slot_full;

  // Configuration registers
  ps2hds_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Sequencer
  ps2hds_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (accept),
    .item    (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  ps2hds_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .load_data  (res),
    .full       (slot_full),
    .take_stall (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // Every accepted item produces a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // Input is stalled while a stalled result is waiting
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result stalled");

  // The end pulse only appears with the sequence idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.finished |-> !out_data.busy_res)
    else $error("finished while busy");

  // No detection result is shown while a sequence runs
  a_busy_no_detect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.busy_res |-> !out_data.detected)
    else $error("detected while busy");

  // Released lines read as zero level
  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.clk_drive || !out_data.clk_level) &&
                  (out_data.data_drive || !out_data.data_level))
    else $error("level set on released line");

endmodule

[tb/ps2_host_detect_sender_tb.sv]
// ----------------------------------------------------------------------------
// ps2_host_detect_sender_tb
// Self-checking bench for the PS/2 host probe. A line-level predictor tracks
// rounds, sends, frame shifting and timeouts per item and checks every
// result. Stimulus covers directed register extremes, zero waits and start
// while busy, followed by randomized clock-line waveforms over many register
// settings, with random input gaps and random output backpressure.
// ----------------------------------------------------------------------------
module ps2_host_detect_sender_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2hds_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HIGH,
    ST_INHIBIT,
    ST_SHIFT
  } probe_state_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Stimulus and expectation stores
  in_item_t  probe_items[$];
  out_item_t expected_lines[$];
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches = 0;
  int        cycles = 0;
  out_item_t want;

  // Clock-line waveform generator state
  logic wave_level = 1'b1;
  int   wave_left  = 0;

  // Predictor state and register shadow
  probe_state_t m_state;
  logic [2:0]   m_round;
  logic [1:0]   m_cmd;
  logic [10:0]  m_frame;
  logic [3:0]   m_bits;
  logic         m_wait_high;
  logic [18:0]  m_ph_tmr;
  logic [15:0]  m_cmd_tmr;
  logic         m_found;
  cfg_t         m_cfg;

  ps2_host_detect_sender i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Predictor: power-up state
  function automatic void clear_probe();
    m_state     = ST_IDLE;
    m_round     = '0;
    m_cmd       = '0;
    m_frame     = '0;
    m_bits      = '0;
    m_wait_high = 1'b0;
    m_ph_tmr    = '0;
    m_cmd_tmr   = '0;
    m_found     = 1'b0;
    m_cfg.timeout_us     = 16'd30000;
    m_cfg.idle_high_us   = 16'd10000;
    m_cfg.inhibit_us     = 12'd500;
    m_cfg.round_delay_us = 19'd350000;
    m_cfg.max_rounds     = 3'd5;
  endfunction

  // Load the frame for the current command and start its high phase
  function automatic void load_send();
    logic [7:0] b;
    b = (m_cmd == 2'd1) ? CMD_PROBE_B : CMD_PROBE_A;
    m_state     = ST_HIGH;
    m_ph_tmr    = '0;
    m_cmd_tmr   = '0;
    m_frame     = {1'b1, ~^b, b, 1'b0};
    m_bits      = '0;
    m_wait_high = 1'b0;
  endfunction

  // Advance to the next command or round after a timeout; return 1 at the end
  function automatic logic drop_send();
    m_cmd = m_cmd + 2'd1;
    if (m_cmd < 2'd3) begin
      load_send();
      return 1'b0;
    end
    m_round = m_round + 3'd1;
    if (m_round >= m_cfg.max_rounds) begin
      m_state = ST_IDLE;
      m_found = 1'b0;
      return 1'b1;
    end
    m_cmd    = '0;
    m_state  = ST_ROUND;
    m_ph_tmr = '0;
    return 1'b0;
  endfunction

  // Step the probe by one item and return the line drives after it
  function automatic out_item_t predict_lines(in_item_t it);
    out_item_t r;
    logic      seq_end;
    r       = '0;
    seq_end = 1'b0;
    if (it.kind) begin
      if (m_state == ST_IDLE) begin
        m_round  = '0;
        m_cmd    = '0;
        m_found  = 1'b0;
        m_state  = ST_ROUND;
        m_ph_tmr = '0;
      end
    end else begin
      // Count send ticks, saturating
      if (m_state inside {ST_HIGH, ST_INHIBIT, ST_SHIFT} && m_cmd_tmr != 16'hFFFF)
        m_cmd_tmr = m_cmd_tmr + 16'd1;
      case (m_state)
        ST_ROUND: begin
          m_ph_tmr = m_ph_tmr + 19'd1;
          if (m_ph_tmr >= m_cfg.round_delay_us) load_send();
        end
        ST_HIGH: begin
          m_ph_tmr = m_ph_tmr + 19'd1;
          if (m_ph_tmr >= 19'(m_cfg.idle_high_us)) begin
            m_state  = ST_INHIBIT;
            m_ph_tmr = '0;
          end
        end
        ST_INHIBIT: begin
          m_ph_tmr = m_ph_tmr + 19'd1;
          if (m_ph_tmr >= 19'(m_cfg.inhibit_us)) begin
            m_state  = ST_SHIFT;
            m_ph_tmr = '0;
          end
        end
        ST_SHIFT: begin
          if (m_cmd_tmr >= m_cfg.timeout_us) begin
            seq_end = drop_send();
          end else if (!m_wait_high) begin
            if (!it.clk_line) m_wait_high = 1'b1;
          end else if (it.clk_line) begin
            m_frame     = m_frame >> 1;
            m_bits      = m_bits + 4'd1;
            m_wait_high = 1'b0;
            if (m_bits >= FRAME_BITS) begin
              m_state = ST_IDLE;
              m_found = 1'b1;
              seq_end = 1'b1;
            end
          end
        end
        default: m_state = ST_IDLE;
      endcase
    end

    // Map the phase onto the line drives
    case (m_state)
      ST_HIGH: begin
        r.clk_drive  = 1'b1;
        r.clk_level  = 1'b1;
        r.data_drive = 1'b1;
        r.data_level = 1'b1;
      end
      ST_INHIBIT: begin
        r.clk_drive  = 1'b1;
        r.data_drive = 1'b1;
        r.data_level = 1'b1;
      end
      ST_SHIFT: begin
        r.data_drive = 1'b1;
        r.data_level = m_frame[0];
      end
      default: ;
    endcase
    r.busy_res = (m_state != ST_IDLE);
    r.finished = seq_end;
    r.detected = m_found;
    return r;
  endfunction

  function automatic void check_field(string name, logic exp_v, logic act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Driver: present items at the falling edge, hold them while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (probe_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= probe_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: check results, then predict for the item accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          check_field("clk_drive", want.clk_drive, out_data.clk_drive);
          check_field("clk_level", want.clk_level, out_data.clk_level);
          check_field("data_drive", want.data_drive, out_data.data_drive);
          check_field("data_level", want.data_level, out_data.data_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("finished", want.finished, out_data.finished);
          check_field("detected", want.detected, out_data.detected);
        end
      end
      if (in_valid && !in_stall) expected_lines.push_back(predict_lines(in_data));
      in_taken <= in_valid && !in_stall;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Write one register and mirror it into the shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TIMEOUT:     m_cfg.timeout_us     = val[15:0];
      REG_IDLE_HIGH:   m_cfg.idle_high_us   = val[15:0];
      REG_INHIBIT:     m_cfg.inhibit_us     = val[11:0];
      REG_ROUND_DELAY: m_cfg.round_delay_us = val[18:0];
      REG_MAX_ROUNDS:  m_cfg.max_rounds     = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [18:0] tmo, input logic [18:0] hi,
                           input logic [18:0] inh, input logic [18:0] dly,
                           input logic [18:0] rounds);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_IDLE_HIGH, hi);
    write_reg(REG_INHIBIT, inh);
    write_reg(REG_ROUND_DELAY, dly);
    write_reg(REG_MAX_ROUNDS, rounds);
  endtask

  // Wait until every item is taken and every result has arrived
  task automatic drain();
    @(negedge clk);
    while (probe_items.size() != 0 || in_valid || expected_lines.size() != 0)
      @(negedge clk);
  endtask

  task automatic push_item(input logic kind, input logic line);
    in_item_t it;
    it.kind     = kind;
    it.clk_line = line;
    probe_items.push_back(it);
  endtask

  // Queue ticks following a square wave on the clock line, with some noise and occasional starts
  task automatic queue_ticks(input int n);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      if (wave_left == 0) begin
        wave_level = ~wave_level;
        wave_left  = $urandom_range(1, 3);
      end
      wave_left--;
      it.kind     = ($urandom_range(99) < 4);
      it.clk_line = ($urandom_range(99) < 10) ? 1'($urandom_range(1)) : wave_level;
      probe_items.push_back(it);
    end
  endtask

  // Rewrite a random subset of registers with short timings
  task automatic pick_settings();
    logic [18:0] v;
    if ($urandom_range(99) < 70) begin
      v = 19'($urandom_range(30, 120));
      if ($urandom_range(9) == 0) v = 19'($urandom_range(1, 12));
      write_reg(REG_TIMEOUT, v);
    end
    if ($urandom_range(99) < 70) write_reg(REG_IDLE_HIGH, 19'($urandom_range(0, 4)));
    if ($urandom_range(99) < 70) write_reg(REG_INHIBIT, 19'($urandom_range(0, 4)));
    if ($urandom_range(99) < 70) write_reg(REG_ROUND_DELAY, 19'($urandom_range(0, 8)));
    if ($urandom_range(99) < 70) write_reg(REG_MAX_ROUNDS, 19'($urandom_range(0, 7)));
  endtask

  initial begin
    clear_probe();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 23;
    recv_idle_pct = 65;

    // Reset settings: ticks while idle, start, start while busy
    push_item(1'b0, 1'b0);
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b1);
    push_item(1'b0, 1'b0);
    push_item(1'b0, 1'b1);
    drain();

    // Largest register values while the round wait runs
    write_all(19'd65535, 19'd65535, 19'd4095, 19'd524287, 19'd7);
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b0);
    drain();

    // All zero: one-tick waits, every send times out, zero rounds act as one
    write_all('0, '0, '0, '0, '0);
    for (int k = 0; k < 12; k++) push_item(1'b0, k[0]);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b0);
    push_item(1'b0, 1'b1);
    drain();

    // Randomized phases, each with fresh settings
    for (int p = 0; p < 24; p++) begin
      if (p == 8) begin
        send_idle_pct = 65;
        recv_idle_pct = 23;
      end else if (p == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_settings();
      push_item(1'b1, 1'($urandom_range(1)));
      queue_ticks($urandom_range(62, 92));
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
